[sv/c8x_pkg.sv]
// c8x_pkg: shared types and constants for the CHIP-8 execute unit.
// No dependencies.
`default_nettype none
package c8x_pkg;
   localparam int MemBytes = 4096;
   localparam int MemAw = $clog2(MemBytes);
   localparam int NumRegs = 16;

   typedef enum logic [1:0] {
      ACT_EXEC = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_READ = 2'd2,
      ACT_REG = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0] action;
      logic [15:0] opcode;
      logic [11:0] mem_addr;
      logic [7:0] mem_data;
      logic [3:0] reg_select;
      logic [15:0] key_states;
   } req_type;

   typedef struct packed {
      logic [11:0] program_counter_out;
      logic [15:0] index_out;
      logic clear_request;
      logic [7:0] read_data;
      logic [7:0] flag_out;
      logic [7:0] delay_value;
      logic [7:0] sound_value;
      logic unsupported;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EXEC = 5'b00010,
      ST_BLOCK = 5'b00100,
      ST_WAIT = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;
endpackage
`default_nettype wire

[sv/c8x_ram.sv]
// c8x_ram: generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module c8x_ram #(
   parameter int Width = 8,
   parameter int Depth = 4096
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(Depth)-1:0] addr,
   input wire logic [Width-1:0] wr_data,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

[sv/chip8_instruction_execute.sv]
// Execute unit for CHIP-8: one opcode or host access per beat, one beat at a time.
// FX55/FX65 move one byte per cycle through the single memory port; a stalled result
// holds the input stalled. A shared 9-bit adder serves 7XNN and 8XY4/8XY5/8XY7.
// Depends on c8x_pkg and c8x_ram.
`default_nettype none
module chip8_instruction_execute (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire c8x_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output c8x_pkg::rsp_type rsp_data
);
   c8x_pkg::state_type state_ff, state_in;
   c8x_pkg::req_type req_ff;
   logic [7:0] v_ff [c8x_pkg::NumRegs];
   logic [11:0] pc_ff;
   logic [15:0] i_ff;
   logic [7:0] dt_ff, st_ff;
   logic [3:0] cnt_ff;
   logic clr_ff, uns_ff, rdsel_ff;
   logic [7:0] rd_ff;
   logic [7:0] mem_rd;
   logic mem_we;
   logic [c8x_pkg::MemAw-1:0] mem_addr;
   logic [7:0] mem_wd;

   logic [3:0] hi, x, y, n;
   logic [7:0] nn, vx, vy;
   logic [8:0] add_a, add_b, add_s;
   logic [15:0] iaddr;
   logic is_store, is_load;

   assign hi = req_ff.opcode[15:12];
   assign x = req_ff.opcode[11:8];
   assign y = req_ff.opcode[7:4];
   assign n = req_ff.opcode[3:0];
   assign nn = req_ff.opcode[7:0];
   assign vx = v_ff[x];
   assign vy = v_ff[y];
   assign is_store = hi == 4'hF && nn == 8'h55;
   assign is_load = hi == 4'hF && nn == 8'h65;
   assign iaddr = i_ff + {12'd0, cnt_ff};

   // shared adder
   always_comb begin
      add_a = {1'b0, vx};
      add_b = {1'b0, vy};
      if (hi == 4'h7) begin
         add_b = {1'b0, nn};
      end else if (hi == 4'h8 && n == 4'h5) begin
         add_b = {1'b0, ~vy} + 9'd1;
      end else if (hi == 4'h8 && n == 4'h7) begin
         add_a = {1'b0, vy};
         add_b = {1'b0, ~vx} + 9'd1;
      end
      add_s = add_a + add_b;
   end

   always_comb begin
      mem_we = 1'b0;
      mem_addr = req_ff.mem_addr[c8x_pkg::MemAw-1:0];
      mem_wd = req_ff.mem_data;
      if (state_ff == c8x_pkg::ST_EXEC && req_ff.action == c8x_pkg::ACT_WRITE) begin
         mem_we = 1'b1;
      end
      if (state_ff == c8x_pkg::ST_BLOCK) begin
         mem_addr = iaddr[c8x_pkg::MemAw-1:0];
         mem_wd = v_ff[cnt_ff];
         mem_we = is_store;
      end
   end

   c8x_ram #(.Width(8), .Depth(c8x_pkg::MemBytes)) u_ram (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr), .wr_data(mem_wd), .rd_data(mem_rd)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         c8x_pkg::ST_IDLE: if (req_valid) state_in = c8x_pkg::ST_EXEC;
         c8x_pkg::ST_EXEC: begin
            if (req_ff.action == c8x_pkg::ACT_EXEC && (is_store || is_load)) begin
               state_in = c8x_pkg::ST_BLOCK;
            end else if (req_ff.action == c8x_pkg::ACT_READ) begin
               state_in = c8x_pkg::ST_WAIT;
            end else begin
               state_in = c8x_pkg::ST_DONE;
            end
         end
         c8x_pkg::ST_BLOCK: if (cnt_ff == x) state_in = c8x_pkg::ST_WAIT;
         c8x_pkg::ST_WAIT: state_in = c8x_pkg::ST_DONE;
         c8x_pkg::ST_DONE: if (!rsp_stall) state_in = c8x_pkg::ST_IDLE;
         default: state_in = c8x_pkg::ST_IDLE;
      endcase
   end

   logic [3:0] ld_idx_ff;
   logic ld_pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= c8x_pkg::ST_IDLE;
         pc_ff <= 12'h200;
         i_ff <= '0;
         dt_ff <= '0;
         st_ff <= '0;
         for (int k = 0; k < c8x_pkg::NumRegs; k++) v_ff[k] <= '0;
         ld_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ld_pend_ff <= state_ff == c8x_pkg::ST_BLOCK && is_load;
         ld_idx_ff <= cnt_ff;
         if (ld_pend_ff) v_ff[ld_idx_ff] <= mem_rd;
         if (state_ff == c8x_pkg::ST_IDLE && req_valid) begin
            req_ff <= req_data;
            cnt_ff <= '0;
            clr_ff <= 1'b0;
            uns_ff <= 1'b0;
            rd_ff <= '0;
            rdsel_ff <= 1'b0;
         end
         if (state_ff == c8x_pkg::ST_BLOCK) begin
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == x) i_ff <= i_ff + {12'd0, x} + 16'd1;
         end
         if (state_ff == c8x_pkg::ST_WAIT && rdsel_ff) rd_ff <= mem_rd;
         if (state_ff == c8x_pkg::ST_EXEC) begin
            case (req_ff.action)
               c8x_pkg::ACT_READ: rdsel_ff <= 1'b1;
               c8x_pkg::ACT_REG: rd_ff <= v_ff[req_ff.reg_select];
               c8x_pkg::ACT_EXEC: begin
                  pc_ff <= pc_ff + 12'd2;
                  case (hi)
                     4'h0: if (req_ff.opcode == 16'h00E0) clr_ff <= 1'b1;
                           else uns_ff <= 1'b1;
                     4'h1: pc_ff <= req_ff.opcode[11:0];
                     4'h2, 4'hC, 4'hD: uns_ff <= 1'b1;
                     4'h3: if (vx == nn) pc_ff <= pc_ff + 12'd4;
                     4'h4: if (vx != nn) pc_ff <= pc_ff + 12'd4;
                     4'h5: if (n != 4'h0) uns_ff <= 1'b1;
                           else if (vx == vy) pc_ff <= pc_ff + 12'd4;
                     4'h9: if (n != 4'h0) uns_ff <= 1'b1;
                           else if (vx != vy) pc_ff <= pc_ff + 12'd4;
                     4'h6: v_ff[x] <= nn;
                     4'h7: v_ff[x] <= add_s[7:0];
                     4'h8: begin
                        case (n)
                           4'h0: v_ff[x] <= vy;
                           4'h1: v_ff[x] <= vx | vy;
                           4'h2: v_ff[x] <= vx & vy;
                           4'h3: v_ff[x] <= vx ^ vy;
                           4'h4, 4'h5, 4'h7: begin
                              v_ff[15] <= {7'd0, add_s[8]};
                              v_ff[x] <= add_s[7:0];
                           end
                           4'h6: begin
                              v_ff[15] <= {7'd0, vx[0]};
                              v_ff[x] <= {1'b0, vx[7:1]};
                           end
                           4'hE: begin
                              v_ff[15] <= {7'd0, vx[7]};
                              v_ff[x] <= {vx[6:0], 1'b0};
                           end
                           default: uns_ff <= 1'b1;
                        endcase
                     end
                     4'hA: i_ff <= {4'd0, req_ff.opcode[11:0]};
                     4'hB: pc_ff <= req_ff.opcode[11:0] + {4'd0, v_ff[0]};
                     4'hE: begin
                        if (nn == 8'h9E) begin
                           if (req_ff.key_states[vx[3:0]]) pc_ff <= pc_ff + 12'd4;
                        end else if (nn == 8'hA1) begin
                           if (!req_ff.key_states[vx[3:0]]) pc_ff <= pc_ff + 12'd4;
                        end else uns_ff <= 1'b1;
                     end
                     default: begin
                        case (nn)
                           8'h07: v_ff[x] <= dt_ff;
                           8'h15: dt_ff <= vx;
                           8'h18: st_ff <= vx;
                           8'h1E: i_ff <= i_ff + {8'd0, vx};
                           8'h55, 8'h65: ;
                           default: uns_ff <= 1'b1;
                        endcase
                     end
                  endcase
               end
               default: ;
            endcase
         end
      end
   end

   assign req_stall = state_ff != c8x_pkg::ST_IDLE;
   assign rsp_valid = state_ff == c8x_pkg::ST_DONE;
   always_comb begin
      rsp_data.program_counter_out = pc_ff;
      rsp_data.index_out = i_ff;
      rsp_data.clear_request = clr_ff;
      rsp_data.read_data = rd_ff;
      rsp_data.flag_out = v_ff[15];
      rsp_data.delay_value = dt_ff;
      rsp_data.sound_value = st_ff;
      rsp_data.unsupported = uns_ff;
   end
endmodule
`default_nettype wire

[tb/sv/tb_chip8_instruction_execute.sv]
// Testbench for chip8_instruction_execute: directed and random opcodes and host accesses,
// checked beat by beat against a behavioral model of the execute unit kept here.
// Depends on c8x_pkg and the RTL of the execute unit.
`default_nettype none
module tb_chip8_instruction_execute;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   c8x_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   c8x_pkg::rsp_type rsp_data;

   chip8_instruction_execute i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   // machine state mirrored from the block
   logic [7:0] v_regs [c8x_pkg::NumRegs];
   logic [11:0] pc;
   logic [15:0] idx;
   logic [7:0] dtimer, stimer;
   logic [7:0] mem [c8x_pkg::MemBytes];
   bit mem_known [c8x_pkg::MemBytes];

   c8x_pkg::rsp_type expected_q [$];
   int mismatches = 0;
   bit hold_rsp = 1'b0;
   int stall_left = 0;

   function automatic logic [11:0] maddr(input logic [31:0] a);
      return 12'((a & 32'hFFF) % c8x_pkg::MemBytes);
   endfunction

   function automatic c8x_pkg::rsp_type predict_beat(input c8x_pkg::req_type r);
      c8x_pkg::rsp_type o;
      logic [3:0] x, y, n;
      logic [7:0] nn, vx, vy, flag, res;
      logic [11:0] nnn;
      logic [8:0] sum;
      bit alu;
      o = '0;
      x = r.opcode[11:8]; y = r.opcode[7:4]; n = r.opcode[3:0];
      nn = r.opcode[7:0]; nnn = r.opcode[11:0];
      alu = 1'b0; flag = '0; res = '0;
      case (c8x_pkg::action_type'(r.action))
         c8x_pkg::ACT_WRITE: begin
            mem[maddr({20'd0, r.mem_addr})] = r.mem_data;
            mem_known[maddr({20'd0, r.mem_addr})] = 1'b1;
         end
         c8x_pkg::ACT_READ: o.read_data = mem[maddr({20'd0, r.mem_addr})];
         c8x_pkg::ACT_REG: o.read_data = v_regs[r.reg_select];
         default: begin
            pc = pc + 12'd2;
            vx = v_regs[x]; vy = v_regs[y];
            case (r.opcode[15:12])
               4'h0: if (r.opcode == 16'h00E0) o.clear_request = 1'b1;
                     else o.unsupported = 1'b1;
               4'h1: pc = nnn;
               4'h2, 4'hC, 4'hD: o.unsupported = 1'b1;
               4'h3: if (vx == nn) pc = pc + 12'd2;
               4'h4: if (vx != nn) pc = pc + 12'd2;
               4'h5: if (n != 4'h0) o.unsupported = 1'b1;
                     else if (vx == vy) pc = pc + 12'd2;
               4'h6: v_regs[x] = nn;
               4'h7: v_regs[x] = vx + nn;
               4'h8: case (n)
                  4'h0: v_regs[x] = vy;
                  4'h1: v_regs[x] = vx | vy;
                  4'h2: v_regs[x] = vx & vy;
                  4'h3: v_regs[x] = vx ^ vy;
                  4'h4: begin
                     sum = {1'b0, vx} + {1'b0, vy};
                     alu = 1'b1; flag = {7'd0, sum[8]}; res = sum[7:0];
                  end
                  4'h5: begin alu = 1'b1; flag = (vy > vx) ? 8'd0 : 8'd1; res = vx - vy; end
                  4'h6: begin alu = 1'b1; flag = {7'd0, vx[0]}; res = vx >> 1; end
                  4'h7: begin alu = 1'b1; flag = (vx > vy) ? 8'd0 : 8'd1; res = vy - vx; end
                  4'hE: begin alu = 1'b1; flag = {7'd0, vx[7]}; res = {vx[6:0], 1'b0}; end
                  default: o.unsupported = 1'b1;
               endcase
               4'h9: if (n != 4'h0) o.unsupported = 1'b1;
                     else if (vx != vy) pc = pc + 12'd2;
               4'hA: idx = {4'd0, nnn};
               4'hB: pc = nnn + {4'd0, v_regs[0]};
               4'hE: if (nn == 8'h9E) begin
                     if (r.key_states[vx[3:0]]) pc = pc + 12'd2;
                  end else if (nn == 8'hA1) begin
                     if (!r.key_states[vx[3:0]]) pc = pc + 12'd2;
                  end else o.unsupported = 1'b1;
               default: case (nn)
                  8'h07: v_regs[x] = dtimer;
                  8'h15: dtimer = vx;
                  8'h18: stimer = vx;
                  8'h1E: idx = idx + {8'd0, vx};
                  8'h55: begin
                     for (int i = 0; i <= int'(x); i++) begin
                        mem[maddr({16'd0, idx} + 32'(i))] = v_regs[i];
                        mem_known[maddr({16'd0, idx} + 32'(i))] = 1'b1;
                     end
                     idx = idx + {12'd0, x} + 16'd1;
                  end
                  8'h65: begin
                     for (int i = 0; i <= int'(x); i++)
                        v_regs[i] = mem[maddr({16'd0, idx} + 32'(i))];
                     idx = idx + {12'd0, x} + 16'd1;
                  end
                  default: o.unsupported = 1'b1;
               endcase
            endcase
            if (alu) begin
               v_regs[15] = flag;
               v_regs[x] = res;
            end
         end
      endcase
      o.program_counter_out = pc;
      o.index_out = idx;
      o.flag_out = v_regs[15];
      o.delay_value = dtimer;
      o.sound_value = stimer;
      return o;
   endfunction

   // never read memory that was never written
   function automatic bit reads_unknown(input c8x_pkg::req_type r);
      if (r.action == c8x_pkg::ACT_READ) return !mem_known[maddr({20'd0, r.mem_addr})];
      if (r.action == c8x_pkg::ACT_EXEC && r.opcode[15:12] == 4'hF &&
          r.opcode[7:0] == 8'h65)
         for (int i = 0; i <= int'(r.opcode[11:8]); i++)
            if (!mem_known[maddr({16'd0, idx} + 32'(i))]) return 1'b1;
      return 1'b0;
   endfunction

   task automatic idle_gap();
      int g;
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 2);
      repeat (g) @(posedge clock);
   endtask

   task automatic send_beat(input c8x_pkg::req_type r);
      c8x_pkg::req_type b;
      b = r;
      if (reads_unknown(b)) b.action = c8x_pkg::ACT_REG;
      expected_q.push_back(predict_beat(b));
      req_valid <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (req_stall);
      req_valid <= 1'b0;
      idle_gap();
   endtask

   function automatic c8x_pkg::req_type make_req(input c8x_pkg::action_type a,
                                                 input logic [15:0] op);
      c8x_pkg::req_type r;
      r.action = a;
      r.opcode = op;
      r.mem_addr = 12'($urandom);
      r.mem_data = 8'($urandom);
      r.reg_select = 4'($urandom);
      r.key_states = 16'($urandom);
      return r;
   endfunction

   task automatic exec_op(input logic [15:0] op);
      send_beat(make_req(c8x_pkg::ACT_EXEC, op));
   endtask

   task automatic drain();
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 9) < 2);
         if ($urandom_range(0, 49) == 0) stall_left <= $urandom_range(5, 30);
      end
   end

   always @(posedge clock) begin
      c8x_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %p", rsp_data);
         end else begin
            want = expected_q.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   task automatic test_directed();
      c8x_pkg::req_type r;
      for (int i = 0; i < 16; i++) begin
         r = make_req(c8x_pkg::ACT_WRITE, '0);
         r.mem_addr = (i < 8) ? 12'(i) : 12'(4088 + i - 8);
         r.mem_data = (i[0]) ? 8'hFF : 8'h00;
         send_beat(r);
      end
      exec_op(16'h00E0); exec_op(16'h00EE); exec_op(16'h6AFF); exec_op(16'h6B01);
      exec_op(16'h8AB4); exec_op(16'h8AB5); exec_op(16'h8BA7); exec_op(16'h6F81);
      exec_op(16'h8FFE); exec_op(16'h8F06); exec_op(16'hAFFC); exec_op(16'hFF55);
      exec_op(16'hAFFC); exec_op(16'hFF65); exec_op(16'hF11E); exec_op(16'h1FFE);
      exec_op(16'h3000); exec_op(16'hBFFF); exec_op(16'hE09E); exec_op(16'hE0A1);
      exec_op(16'hFFFF); exec_op(16'h8AB8);
   endtask

   function automatic logic [15:0] rand_opcode();
      logic [15:0] op;
      logic [7:0] fx [8] = '{8'h07, 8'h15, 8'h18, 8'h1E, 8'h55, 8'h65, 8'h0A, 8'h33};
      op = 16'($urandom);
      case ($urandom_range(0, 9))
         0: op[15:12] = 4'h8;
         1: op[15:12] = 4'h8;
         2: begin op[15:12] = 4'hF; op[7:0] = fx[3'($urandom_range(0, 7))]; end
         3: begin op[15:12] = 4'hE; op[7:0] = $urandom_range(0, 1) ? 8'h9E : 8'hA1; end
         4: begin op[15:12] = 4'h5 + 4'($urandom_range(0, 1) * 4); op[3:0] = 4'h0; end
         5: op[15:12] = $urandom_range(0, 1) ? 4'h6 : 4'h7;
         default: ;
      endcase
      return op;
   endfunction

   task automatic test_random(input int count);
      c8x_pkg::req_type r;
      for (int k = 0; k < count; k++) begin
         r = make_req(c8x_pkg::action_type'($urandom_range(0, 3)), rand_opcode());
         if ($urandom_range(0, 1)) r.action = c8x_pkg::ACT_EXEC;
         send_beat(r);
      end
   endtask

   task automatic test_backpressure();
      c8x_pkg::req_type r;
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int k = 0; k < 20; k++) begin
            r = make_req(c8x_pkg::ACT_REG, '0);
            r.reg_select = 4'(k);
            send_beat(r);
         end
      join
      drain();
   endtask

   initial begin
      for (int i = 0; i < c8x_pkg::NumRegs; i++) v_regs[i] = '0;
      for (int i = 0; i < c8x_pkg::MemBytes; i++) mem_known[i] = 1'b0;
      for (int i = 0; i < c8x_pkg::MemBytes; i++) mem[i] = '0;
      pc = 12'h200; idx = '0; dtimer = '0; stimer = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      drain();
      test_random(280);
      test_backpressure();
      test_random(280);
      drain();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("simulation failed");
      $finish;
   end
endmodule
`default_nettype wire
